[hdl/base64_stream_decoder_assert.svh]
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Concurrent assertion macros shared by the decoder modules.
`ifndef SYNTHESIS
`define B64SD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("base64 decoder assertion failed");
`define B64SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 decoder assertion failed");
`else
`define B64SD_ASSERT(lbl, clk, rst_n, prop)
`define B64SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/b64sd_pkg.sv]
package b64sd_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_PAD = 8'h3D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam logic [5:0] SYM_PLUS = 6'd62;
  localparam logic [5:0] SYM_SLASH = 6'd63;
  localparam logic [7:0] LOWER_BASE = 8'd71;
  localparam logic [7:0] DIGIT_BASE = 8'd4;

  typedef enum logic [1:0] {
    CLS_SYM = 2'd0,
    CLS_PAD = 2'd1,
    CLS_SPACE = 2'd2,
    CLS_BAD = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic [5:0] sym;
    logic last;
  } item_t;

endpackage

[hdl/b64sd_front.sv]
module b64sd_front import b64sd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_char_in,
  input  logic in_last_char,
  output logic fr_valid,
  output item_t fr_item,
  input  logic q_full
);

  logic fr_valid_r;
  logic fr_valid_nxt;
  item_t fr_item_r;
  item_t cls_item;
  logic push;
  logic accept;

  always_comb begin
    cls_item.last = in_last_char;
    cls_item.sym = '0;
    cls_item.cls = CLS_BAD;
    if (in_char_in >= "A" && in_char_in <= "Z") begin
      cls_item.cls = CLS_SYM;
      cls_item.sym = 6'(in_char_in - 8'("A"));
    end else if (in_char_in >= "a" && in_char_in <= "z") begin
      cls_item.cls = CLS_SYM;
      cls_item.sym = 6'(in_char_in - LOWER_BASE);
    end else if (in_char_in >= "0" && in_char_in <= "9") begin
      cls_item.cls = CLS_SYM;
      cls_item.sym = 6'(in_char_in + DIGIT_BASE);
    end else if (in_char_in == CH_PLUS) begin
      cls_item.cls = CLS_SYM;
      cls_item.sym = SYM_PLUS;
    end else if (in_char_in == CH_SLASH) begin
      cls_item.cls = CLS_SYM;
      cls_item.sym = SYM_SLASH;
    end else if (in_char_in == CH_PAD) begin
      cls_item.cls = CLS_PAD;
    end else if (in_char_in == CH_LF || in_char_in == CH_CR ||
                 in_char_in == CH_SP || in_char_in == CH_TAB) begin
      cls_item.cls = CLS_SPACE;
    end
  end

  assign push = fr_valid_r && !q_full;
  assign in_stall = fr_valid_r && q_full;
  assign accept = in_valid && !in_stall;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= cls_item;
    end
  end

  assign fr_valid = fr_valid_r;
  assign fr_item = fr_item_r;

endmodule

[hdl/b64sd_queue.sv]
`include "base64_stream_decoder_assert.svh"

module b64sd_queue import b64sd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  item_t push_item,
  output logic full,
  output logic q_valid,
  output item_t q_item,
  input  logic pop
);

  item_t slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic do_push;
  logic do_pop;

  assign full = (cnt_r == QCNT_W'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `B64SD_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= QCNT_W'(QDEPTH))
  `B64SD_ASSERT_NEXT(a_push_fills, clk, rst_n, do_push && !do_pop, cnt_r != '0)
  `B64SD_ASSERT_NEXT(a_pop_drains, clk, rst_n, do_pop && !do_push, cnt_r != QCNT_W'(QDEPTH))

endmodule

[hdl/b64sd_back.sv]
`include "base64_stream_decoder_assert.svh"

module b64sd_back import b64sd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  item_t q_item,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_data_byte,
  output logic out_has_byte,
  output logic out_status,
  output logic out_message_end
);

  logic [11:0] acc_r, acc_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic pad_r, pad_nxt;
  logic err_r, err_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic has_r, has_nxt;
  logic status_r;
  logic end_r;
  logic [11:0] acc_sh;
  logic [3:0] cnt_add;
  logic [3:0] cnt_left;

  assign pop = q_valid && (!out_valid_r || !out_stall);

  assign acc_sh = {acc_r[5:0], q_item.sym};
  assign cnt_add = cnt_r + 4'd6;
  assign cnt_left = cnt_add - 4'd8;

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pad_nxt = pad_r;
    err_nxt = err_r;
    byte_nxt = '0;
    has_nxt = 1'b0;
    if (!pad_r && !err_r) begin
      case (q_item.cls)
        CLS_PAD: pad_nxt = 1'b1;
        CLS_BAD: err_nxt = 1'b1;
        CLS_SYM: begin
          acc_nxt = acc_sh;
          if (cnt_add >= 4'd8) begin
            cnt_nxt = cnt_left;
            byte_nxt = 8'(acc_sh >> cnt_left);
            has_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_add;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      pad_r <= 1'b0;
      err_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (q_item.last) begin
          acc_r <= '0;
          cnt_r <= '0;
          pad_r <= 1'b0;
          err_r <= 1'b0;
        end else begin
          acc_r <= acc_nxt;
          cnt_r <= cnt_nxt;
          pad_r <= pad_nxt;
          err_r <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r <= byte_nxt;
      has_r <= has_nxt;
      status_r <= err_nxt;
      end_r <= q_item.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data_byte = byte_r;
  assign out_has_byte = has_r;
  assign out_status = status_r;
  assign out_message_end = end_r;

  `B64SD_ASSERT(a_cnt_even, clk, rst_n, !cnt_r[0] && cnt_r <= 4'd6)
  `B64SD_ASSERT(a_pad_err_excl, clk, rst_n, !(pad_r && err_r))
  `B64SD_ASSERT(a_byte_no_err, clk, rst_n, out_valid_r && has_r |-> !status_r)

endmodule

[hdl/base64_stream_decoder.sv]
// Path: a character passes through the classifier register, then the queue, then the decoder output register.
// Throughput: one character per cycle while the output is not stalled and the queue is not full.
// A two-entry queue between the classifier and the decoder lets each side stall on its own.
// Reset: synchronous and active low; it clears the decode state and all valid flags.
// No clearing pass is needed, so the block accepts input in the first cycle after reset.
module base64_stream_decoder import b64sd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_char_in,
  input  logic in_last_char,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_data_byte,
  output logic out_has_byte,
  output logic out_status,
  output logic out_message_end
);

  logic fr_valid;
  item_t fr_item;
  logic q_full;
  logic q_valid;
  item_t q_item;
  logic pop;

  b64sd_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_in(in_char_in),
    .in_last_char(in_last_char),
    .fr_valid(fr_valid),
    .fr_item(fr_item),
    .q_full(q_full)
  );

  b64sd_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(fr_valid),
    .push_item(fr_item),
    .full(q_full),
    .q_valid(q_valid),
    .q_item(q_item),
    .pop(pop)
  );

  b64sd_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_item(q_item),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data_byte(out_data_byte),
    .out_has_byte(out_has_byte),
    .out_status(out_status),
    .out_message_end(out_message_end)
  );

endmodule

[tb/tb_base64_stream_decoder.sv]
module tb_base64_stream_decoder;
  import b64sd_pkg::*;

  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       status;
    logic       last;
  } decode_result_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_has_byte;
  logic       out_status;
  logic       out_message_end;

  // Decoder state as the predictor sees it.
  logic [11:0] acc_bits = '0;
  logic [3:0]  pend_bits = '0;
  logic        pad_seen = 1'b0;
  logic        err_seen = 1'b0;

  decode_result_t expected_results[$];
  logic [7:0]     msg_chars[$];

  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned bytes_out = 0;
  int unsigned error_results = 0;
  int unsigned messages_done = 0;

  bit          bursty = 1'b1;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned run_left = 0;
  bit          run_stalled = 1'b0;
  int unsigned idle_cycles = 0;

  base64_stream_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_byte  (out_data_byte),
    .out_has_byte   (out_has_byte),
    .out_status     (out_status),
    .out_message_end(out_message_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_space(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_CR) || (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic int symbol_index(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c) - int'("A");
    if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
    if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
    if (c == CH_PLUS) return int'(SYM_PLUS);
    if (c == CH_SLASH) return int'(SYM_SLASH);
    return -1;
  endfunction

  function automatic logic [7:0] symbol_char(input int v);
    if (v < 26) return 8'(int'("A") + v);
    if (v < 52) return 8'(int'("a") + v - 26);
    if (v < 62) return 8'(int'("0") + v - 52);
    if (v == int'(SYM_PLUS)) return CH_PLUS;
    return CH_SLASH;
  endfunction

  function automatic logic [7:0] random_space();
    case ($urandom_range(0, 3))
      0: return CH_LF;
      1: return CH_CR;
      2: return CH_SP;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic void append_char(input logic [7:0] c);
    msg_chars = {msg_chars, c};
  endfunction

  function automatic decode_result_t decode_char(input logic [7:0] c, input logic last);
    decode_result_t r;
    int v;
    r = '0;
    if (!pad_seen && !err_seen) begin
      if (c == CH_PAD) begin
        pad_seen = 1'b1;
      end else if (!is_space(c)) begin
        v = symbol_index(c);
        if (v < 0) begin
          err_seen = 1'b1;
        end else begin
          acc_bits = {acc_bits[5:0], 6'(v)};
          pend_bits = pend_bits + 4'd6;
          if (pend_bits >= 4'd8) begin
            pend_bits = pend_bits - 4'd8;
            r.data = 8'(acc_bits >> pend_bits);
            r.has = 1'b1;
          end
        end
      end
    end
    r.status = err_seen;
    r.last = last;
    if (last) begin
      acc_bits = '0;
      pend_bits = '0;
      pad_seen = 1'b0;
      err_seen = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp,
                                      input logic [7:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      fail_count++;
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    in_last_char <= last;
    expected_results = {expected_results, decode_char(c, last)};
    do @(posedge clk); while (in_stall);
    if (burst_left != 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic last_on_end);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], last_on_end && (i == s.len() - 1));
    end
  endtask

  // Builds a message with random content, optional padding and spaces, optionally broken by one stray byte.
  task automatic build_message(input bit broken);
    int unsigned nsym;
    int unsigned npad;
    int unsigned pos;
    msg_chars.delete();
    nsym = $urandom_range(0, 11);
    for (int i = 0; i < nsym; i++) begin
      if ($urandom_range(0, 9) == 0) append_char(random_space());
      append_char(symbol_char($urandom_range(0, 63)));
    end
    npad = (nsym % 4 == 2) ? 2 : ((nsym % 4 == 3) ? 1 : 0);
    if (npad != 0 && $urandom_range(0, 3) != 0) begin
      repeat (npad) append_char(CH_PAD);
      if ($urandom_range(0, 4) == 0) append_char(8'($urandom_range(0, 255)));
    end
    if (broken) begin
      pos = $urandom_range(0, msg_chars.size());
      msg_chars.insert(pos, 8'($urandom_range(0, 255)));
    end
    if (msg_chars.size() == 0) append_char(random_space());
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_chars.size(); i++) begin
      send_char(msg_chars[i], i == msg_chars.size() - 1);
    end
  endtask

  task automatic test_directed();
    stall_pct = 25;
    send_text("TWFu", 1'b1);
    send_text("+/09azAZ", 1'b1);
    send_text("S", 1'b0);
    send_char(CH_SP, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_CR, 1'b0);
    send_text("Q=Z", 1'b0);
    send_char(8'h80, 1'b1);
    send_text("QU", 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("Q", 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_random_messages(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    bursty = 1'b1;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 7) == 0) stall_pct = $urandom_range(0, 70);
      build_message($urandom_range(0, 99) < 15);
      send_message();
    end
  endtask

  task automatic test_noise(input int unsigned n_items);
    stall_pct = 50;
    repeat (n_items) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
  endtask

  // The receiver holds off while the sender keeps offering, so the block fills and stalls.
  task automatic test_backpressure(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    bursty = 1'b0;
    hold_req = 1'b1;
    while (items_sent - start < n_items) begin
      build_message(1'b0);
      send_message();
    end
    bursty = 1'b1;
  endtask

  task automatic test_streaming(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    bursty = 1'b0;
    stall_pct = 0;
    while (items_sent - start < n_items) begin
      build_message(1'b0);
      send_message();
    end
    bursty = 1'b1;
  endtask

  always @(posedge clk) begin : receiver
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_stalled = ($urandom_range(0, 99) < stall_pct);
        run_left = $urandom_range(1, 8);
      end
      run_left--;
      out_stall <= run_stalled;
    end
  end

  always @(posedge clk) begin : result_check
    decode_result_t exp;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %0h has %0b",
                 $time, out_data_byte, out_has_byte);
        $display("%0t: unexpected result status %0b end %0b",
                 $time, out_status, out_message_end);
        fail_count++;
      end else begin
        exp = expected_results.pop_front();
        check_field("data_byte", exp.data, out_data_byte);
        check_field("has_byte", 8'(exp.has), 8'(out_has_byte));
        check_field("status", 8'(exp.status), 8'(out_status));
        check_field("message_end", 8'(exp.last), 8'(out_message_end));
        results_checked++;
        if (exp.has) bytes_out++;
        if (exp.status) error_results++;
        if (exp.last) messages_done++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, no transfer for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_messages(900);
    test_noise(300);
    test_backpressure(80);
    test_streaming(200);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d characters; checked %0d results over %0d messages.",
             items_sent, results_checked, messages_done);
    $display("Results with a decoded byte: %0d, with the error flag set: %0d.",
             bytes_out, error_results);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
